@@ hw/rtl/mhdd_pkg.sv @@
// types, constants and code table for the morse hex digit decoder
`timescale 1ns / 1ps

package mhdd_pkg;

    localparam int unsigned WIDTH_W   = 22;
    localparam int unsigned MAX_SYM   = 5;
    localparam int unsigned COUNT_W   = 3;
    localparam int unsigned CODE_CNT  = 16;
    localparam int unsigned HEX_W     = 4;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DOT_MIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_DASH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_MAX   = 2'd2;

    localparam logic [WIDTH_W-1:0] RST_DOT_MIN  = 22'd30000;
    localparam logic [WIDTH_W-1:0] RST_DOT_DASH = 22'd200000;
    localparam logic [WIDTH_W-1:0] RST_DASH_MAX = 22'd400000;

    typedef enum logic [1:0] {
        SYM_EMPTY = 2'd0,
        SYM_DOT   = 2'd1,
        SYM_DASH  = 2'd2,
        SYM_BAD   = 2'd3
    } t_sym;

    typedef t_sym t_code [MAX_SYM];

    typedef struct packed {
        logic [WIDTH_W-1:0] dot_min;
        logic [WIDTH_W-1:0] dot_dash;
        logic [WIDTH_W-1:0] dash_max;
    } t_cfg;

    typedef struct packed {
        logic             hit;
        logic [HEX_W-1:0] hex;
    } t_match;

    // standard codes for 0-9 and A-F, padded with empty
    localparam t_code CODE_TABLE [CODE_CNT] = '{
        '{SYM_DASH,  SYM_DASH,  SYM_DASH,  SYM_DASH,  SYM_DASH },
        '{SYM_DOT,   SYM_DASH,  SYM_DASH,  SYM_DASH,  SYM_DASH },
        '{SYM_DOT,   SYM_DOT,   SYM_DASH,  SYM_DASH,  SYM_DASH },
        '{SYM_DOT,   SYM_DOT,   SYM_DOT,   SYM_DASH,  SYM_DASH },
        '{SYM_DOT,   SYM_DOT,   SYM_DOT,   SYM_DOT,   SYM_DASH },
        '{SYM_DOT,   SYM_DOT,   SYM_DOT,   SYM_DOT,   SYM_DOT  },
        '{SYM_DASH,  SYM_DOT,   SYM_DOT,   SYM_DOT,   SYM_DOT  },
        '{SYM_DASH,  SYM_DASH,  SYM_DOT,   SYM_DOT,   SYM_DOT  },
        '{SYM_DASH,  SYM_DASH,  SYM_DASH,  SYM_DOT,   SYM_DOT  },
        '{SYM_DASH,  SYM_DASH,  SYM_DASH,  SYM_DASH,  SYM_DOT  },
        '{SYM_DOT,   SYM_DASH,  SYM_EMPTY, SYM_EMPTY, SYM_EMPTY},
        '{SYM_DASH,  SYM_DOT,   SYM_DOT,   SYM_DOT,   SYM_EMPTY},
        '{SYM_DASH,  SYM_DOT,   SYM_DASH,  SYM_DOT,   SYM_EMPTY},
        '{SYM_DASH,  SYM_DOT,   SYM_DOT,   SYM_EMPTY, SYM_EMPTY},
        '{SYM_DOT,   SYM_EMPTY, SYM_EMPTY, SYM_EMPTY, SYM_EMPTY},
        '{SYM_DOT,   SYM_DOT,   SYM_DASH,  SYM_DOT,   SYM_EMPTY}
    };

endpackage

@@ hw/rtl/morse_hex_digit_decoder_core.sv @@
// morse hex digit decoder: input register, symbol store, code match, result register
// a gap transfer reaches the output through the input register and then the result register
// throughput: one transfer per cycle; a gap waits in the input register while the result
//   register is full and not read, and holds off the next transfer meanwhile
// reset: synchronous active low; clears the store, count, overflow flag, valids
//   and loads the default width bounds
`timescale 1ns / 1ps

module morse_hex_digit_decoder_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [mhdd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mhdd_pkg::WIDTH_W-1:0]       i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_command,
    input  logic [mhdd_pkg::WIDTH_W-1:0]       i_mark_width_us,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [mhdd_pkg::HEX_W-1:0]         o_hex_value,
    output logic                               o_decode_error
);
    import mhdd_pkg::*;

    t_cfg               r_cfg;
    logic               r_in_valid;
    logic               r_in_cmd;
    logic [WIDTH_W-1:0] r_in_width;
    t_sym               r_store [MAX_SYM];
    logic [COUNT_W-1:0] r_count;
    logic               r_ovf;
    logic               r_out_valid;
    logic [HEX_W-1:0]   r_hex;
    logic               r_err;

    t_sym   cls_sym;
    t_match match;
    logic   out_free;
    logic   consume;
    logic   is_mark;
    logic   is_gap;
    logic   n_err;

    mhdd_classify u_classify (
        .i_cfg   (r_cfg),
        .i_width (r_in_width),
        .o_sym   (cls_sym)
    );

    mhdd_match u_match (
        .i_store (r_store),
        .o_match (match)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign consume    = r_in_valid && (!r_in_cmd || out_free);
    assign is_mark    = consume && !r_in_cmd;
    assign is_gap     = consume && r_in_cmd;
    assign o_in_ready = !r_in_valid || consume;
    assign n_err      = r_ovf || (r_count == '0) || !match.hit;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dot_min  <= RST_DOT_MIN;
            r_cfg.dot_dash <= RST_DOT_DASH;
            r_cfg.dash_max <= RST_DASH_MAX;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DOT_MIN:  r_cfg.dot_min  <= i_cfg_data;
                REG_DOT_DASH: r_cfg.dot_dash <= i_cfg_data;
                REG_DASH_MAX: r_cfg.dash_max <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_cmd   <= i_command;
            r_in_width <= i_mark_width_us;
        end
    end

    // symbol store
    for (genvar i = 0; i < MAX_SYM; i++) begin : g_store
        always_ff @(posedge i_clk) begin
            if (!i_rst_n || is_gap) begin
                r_store[i] <= SYM_EMPTY;
            end else if (is_mark && (r_count == COUNT_W'(i))) begin
                r_store[i] <= cls_sym;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || is_gap) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (is_mark) begin
            if (r_count < COUNT_W'(MAX_SYM)) begin
                r_count <= r_count + COUNT_W'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (is_gap) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_gap) begin
            r_err <= n_err;
            r_hex <= n_err ? '0 : match.hex;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hex_value    = r_hex;
    assign o_decode_error = r_err;

endmodule

@@ hw/rtl/mhdd_classify.sv @@
// mark width classifier: dot, dash or bad
`timescale 1ns / 1ps

module mhdd_classify (
    input  mhdd_pkg::t_cfg                     i_cfg,
    input  logic [mhdd_pkg::WIDTH_W-1:0]       i_width,
    output mhdd_pkg::t_sym                     o_sym
);
    import mhdd_pkg::*;

    always_comb begin
        if ((i_width > i_cfg.dot_min) && (i_width < i_cfg.dot_dash)) begin
            o_sym = SYM_DOT;
        end else if ((i_width > i_cfg.dot_dash) && (i_width < i_cfg.dash_max)) begin
            o_sym = SYM_DASH;
        end else begin
            o_sym = SYM_BAD;
        end
    end

endmodule

@@ hw/rtl/mhdd_match.sv @@
// exact match of the symbol store against the hex code table
`timescale 1ns / 1ps

module mhdd_match (
    input  mhdd_pkg::t_sym   i_store [mhdd_pkg::MAX_SYM],
    output mhdd_pkg::t_match o_match
);
    import mhdd_pkg::*;

    logic [CODE_CNT-1:0] eq;

    always_comb begin
        for (int k = 0; k < CODE_CNT; k++) begin
            eq[k] = 1'b1;
            for (int j = 0; j < MAX_SYM; j++) begin
                if (i_store[j] != CODE_TABLE[k][j]) begin
                    eq[k] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        o_match.hit = |eq;
        o_match.hex = '0;
        for (int k = CODE_CNT - 1; k >= 0; k--) begin
            if (eq[k]) begin
                o_match.hex = HEX_W'(k);
            end
        end
    end

endmodule
